/* src/double_ended_queue_with_search_macros.svh */
// Assertion macros shared by the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_SEARCH_MACROS_SVH

// Property checked at each rising edge, suspended while reset is asserted.
`define DEQS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at each rising edge, including during reset.
`define DEQS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/deqs_pkg.sv */
// Shared constants, types and ring arithmetic for the deque with search.
package deqs_pkg;

    localparam int DEPTH = 16;
    localparam int DW    = 32;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = AW + 1;
    localparam int SW    = CW + 1;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_SEARCH     = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic pop_take;
        logic scan;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_ok;
        logic search_go;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } t_sts;

    // Position a given offset past a ring index, wrapped into the store.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offs);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(offs);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Position one before a ring index, wrapped into the store.
    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] base);
        logic [AW-1:0] res;
        if (base == '0) begin
            res = AW'(DEPTH - 1);
        end else begin
            res = base - AW'(1);
        end
        return res;
    endfunction

endpackage

/* src/deqs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module deqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/deqs_ctrl.sv */
// Controller state machine that sequences each request of the deque.
module deqs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  deqs_pkg::t_sts i_sts,
    output deqs_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    // Commands and next state from the current state and datapath status.
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_sts.pop_ok) begin
                        n_state = S_POP;
                    end else if (i_sts.search_go) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop_take = 1'b1;
                n_state        = S_RESP;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_hit || i_sts.scan_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* src/deqs_dp.sv */
// Datapath of the deque: ring pointers, entry store, scan and result registers.
module deqs_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [2:0]                   i_req_type,
    input  logic signed [deqs_pkg::DW-1:0] i_value_in,
    input  logic                         i_stall,
    input  deqs_pkg::t_cmd               i_cmd,
    output deqs_pkg::t_sts               o_sts,
    output logic                         o_valid,
    output logic signed [deqs_pkg::DW-1:0] o_value_out,
    output logic                         o_found,
    output logic [1:0]                   o_status,
    output logic [deqs_pkg::CW-1:0]      o_count_out
);

    logic [deqs_pkg::AW-1:0] r_front;
    logic [deqs_pkg::CW-1:0] r_count;
    logic [deqs_pkg::AW-1:0] r_idx;
    logic [deqs_pkg::DW-1:0] r_key;
    logic [deqs_pkg::DW-1:0] r_val;
    logic                    r_found;
    deqs_pkg::t_status       r_status;
    logic                    r_ov;
    logic [deqs_pkg::DW-1:0] r_out_val;
    logic                    r_out_found;
    deqs_pkg::t_status       r_out_status;
    logic [deqs_pkg::CW-1:0] r_out_count;

    logic                    full;
    logic                    empty;
    logic                    we;
    logic [deqs_pkg::AW-1:0] waddr;
    logic [deqs_pkg::AW-1:0] raddr;
    logic [deqs_pkg::DW-1:0] rdata;
    logic [deqs_pkg::CW-1:0] idx_next;
    logic                    is_push;
    logic                    is_pop;
    logic                    is_search;

    assign full     = (r_count == deqs_pkg::CW'(deqs_pkg::DEPTH));
    assign empty    = (r_count == '0);
    assign idx_next = {1'b0, r_idx} + deqs_pkg::CW'(1);

    // Decode of the incoming request.
    always_comb begin
        is_push   = 1'b0;
        is_pop    = 1'b0;
        is_search = 1'b0;
        case (deqs_pkg::t_req'(i_req_type))
            deqs_pkg::REQ_PUSH_FRONT, deqs_pkg::REQ_PUSH_BACK: is_push   = 1'b1;
            deqs_pkg::REQ_POP_FRONT, deqs_pkg::REQ_POP_BACK:   is_pop    = 1'b1;
            deqs_pkg::REQ_SEARCH:                              is_search = 1'b1;
            default: ;
        endcase
    end

    // Store addresses: push target, and the entry a pop or the scan reads.
    always_comb begin
        if (deqs_pkg::t_req'(i_req_type) == deqs_pkg::REQ_PUSH_FRONT) begin
            waddr = deqs_pkg::ring_dec(r_front);
        end else begin
            waddr = deqs_pkg::ring_add(r_front, r_count);
        end
        if (i_cmd.scan) begin
            raddr = deqs_pkg::ring_add(r_front, idx_next);
        end else if (deqs_pkg::t_req'(i_req_type) == deqs_pkg::REQ_POP_BACK) begin
            raddr = deqs_pkg::ring_add(r_front, r_count - deqs_pkg::CW'(1));
        end else begin
            raddr = r_front;
        end
    end

    assign we = i_cmd.start && is_push && !full;

    deqs_ram #(
        .WIDTH(deqs_pkg::DW),
        .DEPTH(deqs_pkg::DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(i_value_in),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Status toward the controller.
    assign o_sts.pop_ok    = is_pop && !empty;
    assign o_sts.search_go = is_search && !empty;
    assign o_sts.scan_hit  = (rdata == r_key);
    assign o_sts.scan_last = (idx_next == r_count);
    assign o_sts.out_free  = !r_ov || !i_stall;

    // Ring pointers: updated once when a request is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.start) begin
            case (deqs_pkg::t_req'(i_req_type))
                deqs_pkg::REQ_PUSH_FRONT: begin
                    if (!full) begin
                        r_front <= deqs_pkg::ring_dec(r_front);
                        r_count <= r_count + deqs_pkg::CW'(1);
                    end
                end
                deqs_pkg::REQ_PUSH_BACK: begin
                    if (!full) begin
                        r_count <= r_count + deqs_pkg::CW'(1);
                    end
                end
                deqs_pkg::REQ_POP_FRONT: begin
                    if (!empty) begin
                        r_front <= deqs_pkg::ring_add(r_front, deqs_pkg::CW'(1));
                        r_count <= r_count - deqs_pkg::CW'(1);
                    end
                end
                deqs_pkg::REQ_POP_BACK: begin
                    if (!empty) begin
                        r_count <= r_count - deqs_pkg::CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Working result of the request in progress.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key   <= i_value_in;
            r_idx   <= '0;
            r_val   <= '0;
            r_found <= 1'b0;
            if (is_push && full) begin
                r_status <= deqs_pkg::ST_FULL;
            end else if (is_pop && empty) begin
                r_status <= deqs_pkg::ST_EMPTY;
            end else begin
                r_status <= deqs_pkg::ST_OK;
            end
        end else if (i_cmd.pop_take) begin
            r_val <= rdata;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + deqs_pkg::AW'(1);
            if (o_sts.scan_hit) begin
                r_val   <= r_key;
                r_found <= 1'b1;
            end
        end
    end

    // Output beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_val    <= r_val;
            r_out_found  <= r_found;
            r_out_status <= r_status;
            r_out_count  <= r_count;
        end
    end

    assign o_valid     = r_ov;
    assign o_value_out = r_out_val;
    assign o_found     = r_out_found;
    assign o_status    = r_out_status;
    assign o_count_out = r_out_count;

endmodule

/* src/double_ended_queue_with_search.sv */
// Top level of the bounded deque of signed 32-bit values with linear search.
//
//   channel  | valid   | stall   | payload
//   ---------+---------+---------+------------------------------------------------
//   request  | i_valid | o_stall | i_req_type, i_value_in
//   result   | o_valid | i_stall | o_value_out, o_found, o_status, o_count_out
//
// A push, a full push, an empty pop or an unknown code passes from the idle state to the result state;
// a good pop adds a pop state between them for the registered read of the entry store.
// A search of a non-empty store compares entries in the scan state up to and including a hit,
// at most the entry count (16); the single read port of the store sets one compare a cycle.
// One request is in flight at a time; a new request is taken and worked while the previous
// beat is stalled, then waits for it to leave. Reset is synchronous and needs no clearing pass.
module double_ended_queue_with_search (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [2:0]                   i_req_type,
    input  logic signed [deqs_pkg::DW-1:0] i_value_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [deqs_pkg::DW-1:0] o_value_out,
    output logic                         o_found,
    output logic [1:0]                   o_status,
    output logic [deqs_pkg::CW-1:0]      o_count_out
);

    deqs_pkg::t_cmd cmd;
    deqs_pkg::t_sts sts;
    logic           busy;

    deqs_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    deqs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_type (i_req_type),
        .i_value_in (i_value_in),
        .i_stall    (i_stall),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .o_value_out(o_value_out),
        .o_found    (o_found),
        .o_status   (o_status),
        .o_count_out(o_count_out)
    );

    // A new request beat is taken only while no request is in flight.
    assign o_stall = busy;

endmodule

/* src/deqs_chk.sv */
// Port-level checker for the deque, bound to the top level.
`include "double_ended_queue_with_search_macros.svh"

module deqs_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic [2:0]                   i_req_type,
    input logic signed [deqs_pkg::DW-1:0] i_value_in,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic signed [deqs_pkg::DW-1:0] o_value_out,
    input logic                         o_found,
    input logic [1:0]                   o_status,
    input logic [deqs_pkg::CW-1:0]      o_count_out
);

    // A stalled result beat keeps its value.
    `DEQS_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_value_out), "result beat changed while stalled")

    // A full push reports a full store.
    `DEQS_ASSERT(a_full_count, i_clk, i_rst_n, o_valid && o_status == deqs_pkg::ST_FULL |-> o_count_out == deqs_pkg::CW'(deqs_pkg::DEPTH), "full status with store not full")

    // An empty pop reports an empty store and no value.
    `DEQS_ASSERT(a_empty_pop, i_clk, i_rst_n, o_valid && o_status == deqs_pkg::ST_EMPTY |-> o_count_out == '0 && o_value_out == '0, "empty status with entries or a value")

    // A hit carries an ok status and a store that is not empty.
    `DEQS_ASSERT(a_found_ok, i_clk, i_rst_n, o_valid && o_found |-> o_status == deqs_pkg::ST_OK && o_count_out != '0, "search hit on an empty store")

    // No result beat and no stall right after reset.
    `DEQS_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid && !o_stall, "result or stall right after reset")

endmodule

bind double_ended_queue_with_search deqs_chk u_chk (.*);
